### rtl/scfc_pkg.sv
// Shared types, codes and helpers for the screen color fade controller.
// No dependencies; imported by every module of the block.
package scfc_pkg;

  localparam int TIME_WIDTH_DEFAULT = 16;
  localparam int LANES              = 4;
  localparam int DIV_STEPS          = 8;
  localparam logic [2:0] STEP_LAST  = 3'(DIV_STEPS - 1);

  localparam logic [31:0] WHITE      = 32'hFFFF_FFFF;
  localparam logic [31:0] NO_TEXTURE = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_SET     = 2'd0;
  localparam logic [1:0] ACT_DISABLE = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic [2:0] KIND_PASSTHRU = 3'd0;
  localparam logic [2:0] KIND_MULTIPLY = 3'd1;
  localparam logic [2:0] KIND_ADD      = 3'd2;
  localparam logic [2:0] KIND_BLEND    = 3'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  filter_kind;
    logic [2:0]  overlay_shape;
    logic [15:0] time_amount;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [7:0]  in_alpha;
    logic [31:0] texture_code;
  } item_beat_t;

  typedef struct packed {
    logic [2:0]  active_kind;
    logic [2:0]  pending_kind;
    logic [2:0]  shape_out;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [31:0] texture_out;
    logic [15:0] time_left;
  } result_beat_t;

  function automatic logic fades_by_alpha(input logic [2:0] kind);
    return (kind == KIND_ADD) || (kind == KIND_BLEND);
  endfunction

endpackage

### rtl/screen_color_fade_controller_core.sv
// Top level of the screen color fade controller: filter state, control FSM,
// four channel lanes and the result register. Depends on scfc_pkg, scfc_lane.
//
// One result beat per item beat, reporting the state after that item. A set,
// a disable, an idle tick or an unused action is accepted and then loads the
// result register. A tick during a fade is accepted, the weighted channel sums
// are formed (ST_LOAD), each channel lane runs its 8-step restoring divide
// (ST_DIVIDE), and the merged color then loads the result register (ST_EMIT).
// New items are taken only while the FSM is idle; a finished result may still
// be waiting downstream at that time.
module screen_color_fade_controller_core import scfc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_beat_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_beat_t result
);

  fsm_state_t state, state_next;

  logic [2:0]            current_kind, current_kind_next;
  logic [2:0]            next_kind, next_kind_next;
  logic [2:0]            shape_reg, shape_reg_next;
  logic [TIME_WIDTH-1:0] fade_length, fade_length_next;
  logic [TIME_WIDTH-1:0] remaining, remaining_next;
  logic [31:0]           start_color, start_color_next;
  logic [31:0]           shown_color, shown_color_next;
  logic [31:0]           target_color, target_color_next;
  logic [31:0]           texture_reg, texture_reg_next;

  logic                  lane_start;
  logic                  emit_fire;
  logic [LANES-1:0]      lane_done_vec;
  logic                  lane_done;
  logic [31:0]           lane_color;

  logic [31:0]           t_ext;
  logic [TIME_WIDTH-1:0] t_in;
  logic [2:0]            s_kind;
  logic [2:0]            s_shape;
  logic [31:0]           s_color;
  logic [31:0]           s_tex;
  logic                  is_set;
  logic [31:0]           rem_ext;

  assign t_ext   = 32'(item.time_amount);
  assign t_in    = t_ext[TIME_WIDTH-1:0];
  assign is_set  = (item.action == ACT_SET) || (item.action == ACT_DISABLE);
  assign s_kind  = (item.action == ACT_DISABLE) ? KIND_PASSTHRU : item.filter_kind;
  assign s_shape = (item.action == ACT_DISABLE) ? shape_reg : item.overlay_shape;
  assign s_color = (item.action == ACT_DISABLE) ? WHITE :
                   {item.in_red, item.in_green, item.in_blue, item.in_alpha};
  assign s_tex   = (item.action == ACT_DISABLE) ? NO_TEXTURE : item.texture_code;

  // FSM
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if ((item.action == ACT_TICK) && (remaining != '0)) state_next = ST_LOAD;
          else                                                 state_next = ST_EMIT;
        end
      end
      ST_LOAD:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (lane_done) state_next = ST_EMIT;
      ST_EMIT:   if (!result_valid || result_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    lane_start = 1'b0;
    emit_fire  = 1'b0;
    case (state)
      ST_IDLE:   item_ready = 1'b1;
      ST_LOAD:   lane_start = 1'b1;
      ST_DIVIDE: ;
      ST_EMIT:   emit_fire = !result_valid || result_ready;
      default:   ;
    endcase
  end

  // filter state update
  always_comb begin
    current_kind_next = current_kind;
    next_kind_next    = next_kind;
    shape_reg_next    = shape_reg;
    fade_length_next  = fade_length;
    remaining_next    = remaining;
    start_color_next  = start_color;
    shown_color_next  = shown_color;
    target_color_next = target_color;
    texture_reg_next  = texture_reg;
    if (item_valid && item_ready) begin
      if (is_set) begin
        shape_reg_next    = s_shape;
        texture_reg_next  = s_tex;
        next_kind_next    = s_kind;
        target_color_next = s_color;
        remaining_next    = t_in;
        fade_length_next  = t_in;
        if (t_in == '0) begin
          current_kind_next = s_kind;
          shown_color_next  = s_color;
          start_color_next  = s_color;
        end else begin
          start_color_next = shown_color;
          if (s_kind == KIND_PASSTHRU) begin
            current_kind_next = next_kind;
            if (next_kind == KIND_MULTIPLY) begin
              target_color_next = WHITE;
            end else if (fades_by_alpha(next_kind)) begin
              target_color_next = {s_color[31:8], 8'h00};
            end
          end else begin
            current_kind_next = s_kind;
            if (next_kind == KIND_PASSTHRU) begin
              if (s_kind == KIND_MULTIPLY) begin
                shown_color_next = WHITE;
              end else if (fades_by_alpha(s_kind)) begin
                shown_color_next = {s_color[31:8], 8'h00};
                start_color_next = {s_color[31:8], 8'h00};
              end
            end
          end
        end
      end else if ((item.action == ACT_TICK) && (remaining != '0)) begin
        remaining_next = (remaining > t_in) ? remaining - t_in : '0;
      end
    end else if ((state == ST_DIVIDE) && lane_done) begin
      shown_color_next = lane_color;
      if (remaining == '0) begin
        current_kind_next = next_kind;
        if (next_kind == KIND_PASSTHRU) texture_reg_next = NO_TEXTURE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_kind <= KIND_PASSTHRU;
      next_kind    <= KIND_PASSTHRU;
      shape_reg    <= '0;
      fade_length  <= '0;
      remaining    <= '0;
      start_color  <= WHITE;
      shown_color  <= WHITE;
      target_color <= WHITE;
      texture_reg  <= NO_TEXTURE;
    end else begin
      current_kind <= current_kind_next;
      next_kind    <= next_kind_next;
      shape_reg    <= shape_reg_next;
      fade_length  <= fade_length_next;
      remaining    <= remaining_next;
      start_color  <= start_color_next;
      shown_color  <= shown_color_next;
      target_color <= target_color_next;
      texture_reg  <= texture_reg_next;
    end
  end

  // channel lanes, lane 0 is alpha
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    scfc_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .start   (lane_start),
      .length  (fade_length),
      .left    (remaining),
      .prev_ch (start_color[8*i +: 8]),
      .next_ch (target_color[8*i +: 8]),
      .done    (lane_done_vec[i]),
      .quot    (lane_color[8*i +: 8])
    );
  end

  assign lane_done = &lane_done_vec;

  // result register
  assign rem_ext = 32'(remaining);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      result.active_kind  <= current_kind;
      result.pending_kind <= next_kind;
      result.shape_out    <= shape_reg;
      result.out_red      <= shown_color[31:24];
      result.out_green    <= shown_color[23:16];
      result.out_blue     <= shown_color[15:8];
      result.out_alpha    <= shown_color[7:0];
      result.texture_out  <= texture_reg;
      result.time_left    <= rem_ext[15:0];
    end
  end

endmodule

### rtl/scfc_lane.sv
// One color channel lane: weighted sum of start and target, then an
// 8-step restoring divide by the fade length. Depends on scfc_pkg.
module scfc_lane import scfc_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] length,
  input  logic [TIME_WIDTH-1:0] left,
  input  logic [7:0]            prev_ch,
  input  logic [7:0]            next_ch,
  output logic                  done,
  output logic [7:0]            quot
);

  localparam int NW = TIME_WIDTH + 8;

  logic [TIME_WIDTH-1:0] left_clamp;
  logic [TIME_WIDTH-1:0] weight;
  logic [NW-1:0]         prod_next;
  logic [NW-1:0]         prod_prev;

  logic          busy;
  logic [2:0]    step;
  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [7:0]    q;
  logic          zero_len;
  logic [7:0]    nx;

  assign left_clamp = (left > length) ? length : left;
  assign weight     = length - left_clamp;
  assign prod_next  = NW'(next_ch) * NW'(weight);
  assign prod_prev  = NW'(prev_ch) * NW'(left_clamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= prod_next + prod_prev;
      dvs      <= NW'({length, 7'b0});
      q        <= '0;
      zero_len <= (length == '0);
      nx       <= next_ch;
    end else if (busy) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        q   <= {q[6:0], 1'b1};
      end else begin
        q   <= {q[6:0], 1'b0};
      end
      dvs <= dvs >> 1;
    end
  end

  assign quot = zero_len ? nx : q;

endmodule

### rtl/scfc_checker.sv
// Port-level checks for the screen color fade controller, bound to the top.
// Depends on scfc_pkg and screen_color_fade_controller_core.
module scfc_checker import scfc_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_ready,
  input item_beat_t   item,
  input logic         result_valid,
  input logic         result_ready,
  input result_beat_t result
);

  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(item_valid && item_ready)
                         - 2'(result_valid && result_ready);
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 2'd0)
    else $error("result beat without an item");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many items outstanding");

  a_idle_kinds: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.time_left == 16'd0) |->
      result.active_kind == result.pending_kind)
    else $error("idle filter with a pending kind change");

endmodule

bind screen_color_fade_controller_core scfc_checker u_scfc_checker (.*);

### test/tb_screen_color_fade_controller_core.sv
// Self-checking testbench for screen_color_fade_controller_core: directed and
// random set, disable and tick beats against an in-bench fade predictor.
// Depends on scfc_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_screen_color_fade_controller_core;
  import scfc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 950;
  localparam int QUIET_LO = 400;
  localparam int QUIET_HI = 560;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_beat_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_beat_t result;

  item_beat_t items_to_send[$];
  result_beat_t fade_expected[$];
  int sent_count = 0;
  int mismatches = 0;
  int drain_a = -1;
  int drain_b = -1;
  logic quiet;

  // predicted block state
  logic [2:0]  cur_kind = KIND_PASSTHRU;
  logic [2:0]  nxt_kind = KIND_PASSTHRU;
  logic [2:0]  shape_q = 3'd0;
  logic [15:0] fade_len = 16'd0;
  logic [15:0] remain = 16'd0;
  logic [31:0] start_rgba = WHITE;
  logic [31:0] shown_rgba = WHITE;
  logic [31:0] target_rgba = WHITE;
  logic [31:0] tex_q = NO_TEXTURE;

  assign quiet = (sent_count >= QUIET_LO) && (sent_count < QUIET_HI);

  screen_color_fade_controller_core u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic step_fade(input item_beat_t it, output result_beat_t res);
    logic [2:0]  kind;
    logic [2:0]  shp;
    logic [15:0] t;
    logic [31:0] rgba;
    logic [31:0] tex;
    logic [31:0] nx;
    logic [31:0] pv;
    logic [31:0] wt;
    logic [31:0] lerp;
    logic [31:0] mix;
    kind = it.filter_kind;
    shp  = it.overlay_shape;
    t    = it.time_amount;
    rgba = {it.in_red, it.in_green, it.in_blue, it.in_alpha};
    tex  = it.texture_code;
    if (it.action == ACT_DISABLE) begin
      kind = KIND_PASSTHRU;
      shp  = shape_q;
      rgba = WHITE;
      tex  = NO_TEXTURE;
    end
    if (it.action == ACT_SET || it.action == ACT_DISABLE) begin
      if (t == 16'd0) begin
        fade_len    = '0;
        remain      = '0;
        shape_q     = shp;
        nxt_kind    = kind;
        cur_kind    = kind;
        target_rgba = rgba;
        shown_rgba  = rgba;
        start_rgba  = rgba;
        tex_q       = tex;
      end else begin
        target_rgba = rgba;
        start_rgba  = shown_rgba;
        shape_q     = shp;
        tex_q       = tex;
        remain      = t;
        fade_len    = t;
        cur_kind    = nxt_kind;
        nxt_kind    = kind;
        if (kind == KIND_PASSTHRU) begin
          if (cur_kind == KIND_MULTIPLY) begin
            target_rgba = WHITE;
          end else if (cur_kind == KIND_ADD || cur_kind == KIND_BLEND) begin
            target_rgba[7:0] = 8'h00;
          end
        end else begin
          if (cur_kind == KIND_PASSTHRU) begin
            if (kind == KIND_MULTIPLY) begin
              shown_rgba = WHITE;
            end else if (kind == KIND_ADD || kind == KIND_BLEND) begin
              shown_rgba = {target_rgba[31:8], 8'h00};
              start_rgba = shown_rgba;
            end
          end
          cur_kind = nxt_kind;
        end
      end
    end else if (it.action == ACT_TICK && remain != 16'd0) begin
      remain = (remain > t) ? remain - t : 16'd0;
      mix = '0;
      for (int sh = 0; sh < 32; sh += 8) begin
        nx = (target_rgba >> sh) & 32'hFF;
        pv = (start_rgba >> sh) & 32'hFF;
        if (fade_len == 16'd0) begin
          lerp = nx;
        end else begin
          wt = (remain > fade_len) ? 32'(fade_len) : 32'(remain);
          lerp = (nx * (32'(fade_len) - wt) + pv * wt) / 32'(fade_len);
          if (lerp > 32'hFF) lerp = 32'hFF;
        end
        mix |= lerp << sh;
      end
      shown_rgba = mix;
      if (remain == 16'd0) begin
        cur_kind = nxt_kind;
        if (cur_kind == KIND_PASSTHRU) tex_q = NO_TEXTURE;
      end
    end
    res.active_kind  = cur_kind;
    res.pending_kind = nxt_kind;
    res.shape_out    = shape_q;
    res.out_red      = shown_rgba[31:24];
    res.out_green    = shown_rgba[23:16];
    res.out_blue     = shown_rgba[15:8];
    res.out_alpha    = shown_rgba[7:0];
    res.texture_out  = tex_q;
    res.time_left    = remain;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 200)
      $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    if (fade_expected.size() == 0) begin
      report_mismatch("result beat with nothing expected", 32'(got.time_left), 32'd0);
    end else begin
      want = fade_expected.pop_front();
      if (got.active_kind !== want.active_kind)
        report_mismatch("active_kind", 32'(got.active_kind), 32'(want.active_kind));
      if (got.pending_kind !== want.pending_kind)
        report_mismatch("pending_kind", 32'(got.pending_kind), 32'(want.pending_kind));
      if (got.shape_out !== want.shape_out)
        report_mismatch("shape_out", 32'(got.shape_out), 32'(want.shape_out));
      if (got.out_red !== want.out_red)
        report_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
      if (got.out_green !== want.out_green)
        report_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
      if (got.out_blue !== want.out_blue)
        report_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
      if (got.out_alpha !== want.out_alpha)
        report_mismatch("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
      if (got.texture_out !== want.texture_out)
        report_mismatch("texture_out", got.texture_out, want.texture_out);
      if (got.time_left !== want.time_left)
        report_mismatch("time_left", 32'(got.time_left), 32'(want.time_left));
    end
  endtask

  function automatic item_beat_t mk(input logic [1:0] act, input logic [2:0] kind,
                                    input logic [2:0] shp, input logic [15:0] t,
                                    input logic [31:0] rgba, input logic [31:0] tex);
    item_beat_t b;
    b.action        = act;
    b.filter_kind   = kind;
    b.overlay_shape = shp;
    b.time_amount   = t;
    {b.in_red, b.in_green, b.in_blue, b.in_alpha} = rgba;
    b.texture_code  = tex;
    return b;
  endfunction

  function automatic logic [31:0] rand_tex();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return NO_TEXTURE;
    if (r < 30) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 300));
    if (r < 85) return 16'($urandom_range(1, 65535));
    if (r < 92) return 16'hFFFF;
    if (r < 96) return 16'd1;
    return 16'd0;
  endfunction

  function automatic item_beat_t rand_tick(input logic [15:0] dt);
    return mk(ACT_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), dt,
              $urandom, $urandom);
  endfunction

  // driver
  always @(posedge clk) begin : drive
    result_beat_t want;
    logic pause;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        step_fade(item, want);
        fade_expected.push_back(want);
        sent_count++;
      end
      if (!item_valid || item_ready) begin
        pause = (sent_count == drain_a || sent_count == drain_b) &&
                (fade_expected.size() != 0);
        if (items_to_send.size() != 0 && !pause &&
            (quiet || $urandom_range(0, 99) >= 22)) begin
          item       <= items_to_send.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_result(result);
      result_ready <= quiet || ($urandom_range(0, 99) >= 22);
    end
  end

  initial begin : stimulus
    int counted;
    int pick;
    int elapsed;
    int ticks;
    logic [15:0] dur;
    logic [15:0] dt;
    logic [1:0] act;

    // idle tick and unused action on reset state
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd0, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_UNUSED, 3'd7, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // immediate multiply, then fade to passthru from multiply
    items_to_send.push_back(mk(ACT_SET, KIND_MULTIPLY, 3'd7, 16'd0, 32'h0000_0000, 32'd0));
    items_to_send.push_back(mk(ACT_SET, KIND_PASSTHRU, 3'd2, 16'd100, 32'h1234_5678, 32'd77));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd40, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd0, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'hFFFF, 32'd0, 32'd0));
    // add then blend while not passthru
    items_to_send.push_back(mk(ACT_SET, KIND_ADD, 3'd1, 16'd0, 32'hFFFF_FFFF, 32'hA5A5_5A5A));
    items_to_send.push_back(mk(ACT_SET, KIND_BLEND, 3'd3, 16'd50, 32'h80FF_0040, 32'd5));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd50, 32'd0, 32'd0));
    // disable fading out of blend, saturating tick ends it
    items_to_send.push_back(mk(ACT_DISABLE, 3'd5, 3'd6, 16'd30, 32'h0102_0304, 32'd9));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd10, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd25, 32'd0, 32'd0));
    // multiply from passthru starts at white
    items_to_send.push_back(mk(ACT_SET, KIND_MULTIPLY, 3'd4, 16'd20, 32'h0000_00FF, 32'd1));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd20, 32'd0, 32'd0));
    // immediate disable keeps shape, then add from passthru at full time
    items_to_send.push_back(mk(ACT_DISABLE, 3'd2, 3'd0, 16'd0, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_SET, KIND_ADD, 3'd5, 16'hFFFF, 32'h1234_5678, NO_TEXTURE));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd1, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'hFFFE, 32'd0, 32'd0));
    // blend from passthru
    items_to_send.push_back(mk(ACT_DISABLE, 3'd0, 3'd0, 16'd0, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_SET, KIND_BLEND, 3'd1, 16'd3, 32'hFF00_FF00, 32'd3));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'd2, 32'd0, 32'd0));
    // plain type, unused action mid fade
    items_to_send.push_back(mk(ACT_SET, 3'd7, 3'd5, 16'd200, 32'hFFFF_FFFF, 32'h0000_FFFF));
    items_to_send.push_back(mk(ACT_UNUSED, 3'd0, 3'd0, 16'd0, 32'd0, 32'd0));
    items_to_send.push_back(mk(ACT_TICK, 3'd0, 3'd0, 16'h8000, 32'd0, 32'd0));

    drain_a = items_to_send.size();
    drain_b = drain_a + ITEM_TARGET / 2;

    counted = 0;
    while (counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        dur = pick_time();
        items_to_send.push_back(mk(ACT_SET, 3'($urandom_range(0, 7)),
                                   3'($urandom_range(0, 7)), dur, $urandom, rand_tex()));
        counted++;
        elapsed = 0;
        ticks = 0;
        while (elapsed < dur && ticks < 10 && $urandom_range(0, 99) >= 5) begin
          if ($urandom_range(0, 9) == 0) dt = 16'($urandom_range(0, 65535));
          else dt = 16'($urandom_range(0, dur / 3 + 1));
          items_to_send.push_back(rand_tick(dt));
          elapsed += dt;
          ticks++;
          counted++;
        end
      end else if (pick < 70) begin
        dur = ($urandom_range(0, 3) == 0) ? 16'd0 : pick_time();
        items_to_send.push_back(mk(ACT_DISABLE, 3'($urandom_range(0, 7)),
                                   3'($urandom_range(0, 7)), dur, $urandom, $urandom));
        counted++;
      end else if (pick < 80) begin
        items_to_send.push_back(mk(ACT_SET, 3'($urandom_range(0, 7)),
                                   3'($urandom_range(0, 7)), 16'd0, $urandom, rand_tex()));
        counted++;
      end else if (pick < 88) begin
        items_to_send.push_back(rand_tick(16'($urandom_range(0, 65535))));
        counted++;
      end else begin
        act = 2'($urandom_range(0, 3));
        items_to_send.push_back(mk(act, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                   16'($urandom_range(0, 65535)), $urandom, $urandom));
        if (act != ACT_UNUSED) counted++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (items_to_send.size() != 0 || item_valid);
    while (fade_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && fade_expected.size() == 0) begin
      $display("[screen_color_fade_controller_core] OK");
    end else begin
      $display("[screen_color_fade_controller_core] ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("[screen_color_fade_controller_core] ERROR");
    $finish;
  end

endmodule

### screen_color_fade_controller_core.f
rtl/scfc_pkg.sv
rtl/scfc_lane.sv
rtl/screen_color_fade_controller_core.sv
rtl/scfc_checker.sv
test/tb_screen_color_fade_controller_core.sv
